@@ src/gtm_pkg.sv @@
// ----------------------------------------------------------------------------
// gtm_pkg
// Shared constants and types for the gate to MIDI note event converter.
// ----------------------------------------------------------------------------
package gtm_pkg;

    localparam int CHANNELS = 16;
    localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [4:0] CH_LIMIT   = 5'(CHANNELS);
    localparam logic [6:0] RESET_NOTE = 7'd24;
    localparam logic [6:0] OFF_VALUE  = 7'd64;
    localparam logic [3:0] STAT_ON    = 4'h9;
    localparam logic [3:0] STAT_OFF   = 4'h8;

    typedef struct packed {
        logic [6:0] note;
        logic       gate;
        logic [6:0] velocity;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_entry RESET_ENTRY = '{note: RESET_NOTE, gate: 1'b0, velocity: 7'd0};

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] note_byte;
        logic [6:0] value_byte;
        logic       last_of_run;
    } t_msg;

    typedef struct packed {
        logic [1:0] cnt;
        t_msg       m0;
        t_msg       m1;
    } t_push;

endpackage

@@ src/gtm_ram.sv @@
// ----------------------------------------------------------------------------
// gtm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/gtm_outq.sv @@
// ----------------------------------------------------------------------------
// gtm_outq
// Two-entry output queue; takes up to two messages per push.
// ----------------------------------------------------------------------------
module gtm_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gtm_pkg::t_push i_push,
    input  logic          i_ready,
    output logic          o_valid,
    output gtm_pkg::t_msg o_head,
    output logic [1:0]    o_cnt,
    output logic          o_pop
);

    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    gtm_pkg::t_msg r_q0;
    gtm_pkg::t_msg r_q1;
    gtm_pkg::t_msg n_q0;
    gtm_pkg::t_msg n_q1;
    logic [1:0]    w_base;
    gtm_pkg::t_msg w_a0;

    assign o_pop = (r_cnt != 2'd0) && i_ready;

    always_comb begin
        w_a0   = o_pop ? r_q1 : r_q0;
        w_base = r_cnt - {1'b0, o_pop};
        n_q0   = w_a0;
        n_q1   = r_q1;
        case (w_base)
            2'd0: begin
                n_q0 = i_push.m0;
                n_q1 = i_push.m1;
            end
            2'd1: begin
                n_q0 = w_a0;
                n_q1 = i_push.m0;
            end
            default: begin
                n_q0 = w_a0;
                n_q1 = r_q1;
            end
        endcase
        n_cnt = w_base + i_push.cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q0;
    assign o_cnt   = r_cnt;

endmodule

@@ src/gate_to_midi_note_events.sv @@
// ----------------------------------------------------------------------------
// gate_to_midi_note_events
// Path: the input is registered in stage 1, its messages in the output queue.
// Throughput: one input per cycle when it yields zero or one message and
// i_ready does not hold the queue; a note-off/note-on pair needs both entries
// of the two-entry output queue, which the single output port drains.
// Reset: clears the per-channel valid bits, so every channel reads as note 24,
// gate off, velocity 0 at once; no clearing pass.
// ----------------------------------------------------------------------------
module gate_to_midi_note_events (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [3:0] i_channel,
    input  logic [6:0] i_note,
    input  logic       i_gate,
    input  logic [6:0] i_velocity,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_status_byte,
    output logic [6:0] o_note_byte,
    output logic [6:0] o_value_byte,
    output logic       o_last_of_run
);

    localparam int AW = gtm_pkg::ADDR_W;

    logic                  r_s1_valid;
    logic                  n_s1_valid;
    logic [3:0]            r_s1_ch;
    logic [6:0]            r_s1_note;
    logic                  r_s1_gate;
    logic [6:0]            r_s1_vel;
    logic                  r_fwd_hit;
    logic                  n_fwd_hit;
    gtm_pkg::t_entry       r_fwd_data;
    logic [gtm_pkg::CHANNELS-1:0] r_vld;

    logic                  w_accept;
    logic [AW-1:0]         w_raddr;
    logic [AW-1:0]         w_s1_addr;
    logic [gtm_pkg::ENTRY_W-1:0] w_rdata;
    gtm_pkg::t_entry       w_held;
    gtm_pkg::t_entry       w_new;
    logic                  w_ch_ok;
    logic                  w_vld_bit;
    logic                  w_same;
    gtm_pkg::t_push        w_push;
    gtm_pkg::t_msg         w_m0;
    gtm_pkg::t_msg         w_m1;
    logic [1:0]            w_msgs;
    logic                  w_adv;
    logic                  w_we;
    logic [1:0]            w_cnt;
    logic                  w_pop;
    logic [2:0]            w_space;
    gtm_pkg::t_msg         w_head;
    gtm_pkg::t_msg         w_on;
    gtm_pkg::t_msg         w_off;

    assign w_accept  = i_valid && o_ready;
    assign w_s1_addr = r_s1_ch[AW-1:0];
    assign w_raddr   = w_accept ? i_channel[AW-1:0] : w_s1_addr;

    gtm_ram #(
        .WIDTH (gtm_pkg::ENTRY_W),
        .DEPTH (gtm_pkg::CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_s1_addr),
        .i_wdata (w_new),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // held state: forwarded write, stored entry, or reset value
    always_comb begin
        w_ch_ok   = ({1'b0, r_s1_ch} < gtm_pkg::CH_LIMIT);
        w_vld_bit = w_ch_ok && r_vld[w_s1_addr];
        if (r_fwd_hit) begin
            w_held = r_fwd_data;
        end else if (w_vld_bit) begin
            w_held = gtm_pkg::t_entry'(w_rdata);
        end else begin
            w_held = gtm_pkg::RESET_ENTRY;
        end
        w_new.note     = r_s1_note;
        w_new.gate     = r_s1_gate;
        w_new.velocity = r_s1_vel;
        w_same = (w_new == w_held);
    end

    always_comb begin
        w_on.status_byte  = {gtm_pkg::STAT_ON, r_s1_ch};
        w_on.note_byte    = r_s1_note;
        w_on.value_byte   = r_s1_vel;
        w_on.last_of_run  = 1'b1;
        w_off.status_byte = {gtm_pkg::STAT_OFF, r_s1_ch};
        w_off.note_byte   = w_held.note;
        w_off.value_byte  = gtm_pkg::OFF_VALUE;
        w_off.last_of_run = 1'b1;
        w_msgs = 2'd0;
        w_m0   = w_on;
        w_m1   = w_on;
        if (!w_ch_ok || w_same || (!r_s1_gate && !w_held.gate)) begin
            w_msgs = 2'd0;
        end else if (r_s1_gate && !w_held.gate) begin
            w_msgs = 2'd1;
        end else if (!r_s1_gate && w_held.gate) begin
            w_msgs = 2'd1;
            w_m0   = w_off;
        end else begin
            w_msgs = 2'd2;
            w_m0   = w_off;
            w_m0.last_of_run = 1'b0;
        end
    end

    // advance when the queue has room for this transaction's messages
    assign w_space = 3'd2 - {1'b0, w_cnt} + {2'b00, w_pop};
    assign w_adv   = r_s1_valid && ({1'b0, w_msgs} <= w_space);
    assign w_we    = w_adv && (w_msgs != 2'd0);
    assign w_push  = {(w_adv ? w_msgs : 2'd0), w_m0, w_m1};
    assign o_ready = !r_s1_valid || w_adv;

    always_comb begin
        n_s1_valid = w_accept || (r_s1_valid && !w_adv);
        n_fwd_hit  = r_fwd_hit;
        if (w_accept) begin
            n_fwd_hit = w_we && (i_channel == r_s1_ch);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_vld      <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_fwd_hit  <= n_fwd_hit;
            if (w_we) begin
                r_vld[w_s1_addr] <= 1'b1;
            end
        end
        if (w_accept) begin
            r_s1_ch    <= i_channel;
            r_s1_note  <= i_note;
            r_s1_gate  <= i_gate;
            r_s1_vel   <= i_velocity;
            r_fwd_data <= w_new;
        end
    end

    gtm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_head  (w_head),
        .o_cnt   (w_cnt),
        .o_pop   (w_pop)
    );

    assign o_status_byte = w_head.status_byte;
    assign o_note_byte   = w_head.note_byte;
    assign o_value_byte  = w_head.value_byte;
    assign o_last_of_run = w_head.last_of_run;

`ifndef SYNTHESIS
    a_first_is_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> o_status_byte[7:4] == gtm_pkg::STAT_OFF)
        else $error("non-final message is not a note-off");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_run
        |=> o_valid && o_status_byte[7:4] == gtm_pkg::STAT_ON && o_last_of_run)
        else $error("note-on does not follow note-off of a pair");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt != 2'd3)
        else $error("output queue overflow");

    a_write_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_s1_valid && w_ch_ok)
        else $error("state write without a valid in-range transaction");
`endif

endmodule
